@@ hw/rtl/rdbe_pkg.sv @@
`timescale 1ns / 1ps

package rdbe_pkg;

    // signed coordinate wide enough for every derived point
    localparam int CW    = 14;
    // unsigned image dimension width (up to 4095)
    localparam int DIM_W = 12;
    localparam int CNT_W = 17;

    typedef logic signed [CW-1:0] coord_t;

    typedef enum logic [2:0] {
        OP_LINE     = 3'd0,
        OP_OUTLINE  = 3'd1,
        OP_FILL     = 3'd2,
        OP_COPY     = 3'd3,
        OP_COPY_INV = 3'd4,
        OP_MIRROR_H = 3'd5,
        OP_MIRROR_V = 3'd6,
        OP_READ     = 3'd7
    } op_t;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        op_t               op;
        logic signed [11:0] x1;
        logic signed [11:0] y1;
        logic signed [11:0] x2;
        logic signed [11:0] y2;
        logic signed [11:0] x3;
        logic signed [11:0] y3;
        logic [7:0]         color;
    } cmd_t;

    // pixel access request into the frame store
    typedef struct packed {
        logic       wr;
        logic       rd;
        coord_t     x;
        coord_t     y;
        logic [7:0] data;
    } px_req_t;

    typedef struct packed {
        logic [7:0]       pixel_value;
        logic [CNT_W-1:0] pixels_written;
    } res_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_LINE,
        S_OUT_H,
        S_OUT_V,
        S_FILL,
        S_BLIT_RD,
        S_BLIT_WR,
        S_READ_RD,
        S_READ_WAIT,
        S_DONE
    } seq_state_t;

endpackage

@@ hw/rtl/rdbe_fb.sv @@
`timescale 1ns / 1ps

module rdbe_fb
    import rdbe_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [DIM_W-1:0] eff_w,
    input  logic [DIM_W-1:0] eff_h,
    input  px_req_t          req,
    output logic             hit,
    output logic [7:0]       rd_data,
    output logic             clr_busy
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [7:0]       mem [DEPTH];
    logic [7:0]       q_reg;
    logic             rd_ok_reg, rd_ok_next;
    logic [AW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic             clr_busy_reg, clr_busy_next;
    logic [DIM_W-1:0] xu, yu;
    logic [31:0]      lin;
    logic [AW-1:0]    addr;

    // bounds check and linear address
    always_comb begin
        hit = !req.x[CW-1] && !req.y[CW-1]
            && (req.x < $signed({2'b00, eff_w}))
            && (req.y < $signed({2'b00, eff_h}));
        xu   = req.x[DIM_W-1:0];
        yu   = req.y[DIM_W-1:0];
        lin  = 32'(yu) * 32'(MAX_WIDTH) + 32'(xu);
        addr = lin[AW-1:0];
    end

    // storage: clearing pass first, then one access per cycle
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_cnt_reg] <= '0;
        end else if (req.wr && hit) begin
            mem[addr] <= req.data;
        end
        if (req.rd) begin
            q_reg <= mem[addr];
        end
    end

    always_comb begin
        clr_cnt_next  = clr_cnt_reg;
        clr_busy_next = clr_busy_reg;
        rd_ok_next    = req.rd ? hit : rd_ok_reg;
        if (clr_busy_reg) begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == AW'(DEPTH - 1)) begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
            rd_ok_reg    <= 1'b0;
        end else begin
            clr_cnt_reg  <= clr_cnt_next;
            clr_busy_reg <= clr_busy_next;
            rd_ok_reg    <= rd_ok_next;
        end
    end

    // source outside the image reads as zero
    assign rd_data  = rd_ok_reg ? q_reg : 8'd0;
    assign clr_busy = clr_busy_reg;

endmodule

@@ hw/rtl/rdbe_seq.sv @@
`timescale 1ns / 1ps

module rdbe_seq
    import rdbe_pkg::*;
#(
    parameter int PIXEL_MAX = 255
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  cmd_t             cmd,
    input  logic [DIM_W-1:0] eff_w,
    input  logic [DIM_W-1:0] eff_h,
    output logic             idle,
    output logic             done,
    input  logic             res_take,
    output res_t             res,
    output px_req_t          req,
    input  logic             hit,
    input  logic [7:0]       rd_data
);

    localparam logic [7:0] PMAX8 = 8'(PIXEL_MAX);

    seq_state_t       state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    coord_t           a_reg, a_next, a_hi_reg, a_hi_next;
    coord_t           b_reg, b_next, b_lo_reg, b_lo_next, b_hi_reg, b_hi_next;
    logic             sub_reg, sub_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       pix_reg, pix_next;
    logic [11:0]      steps_reg, steps_next, adx_reg, adx_next, ady_reg, ady_next;
    logic [11:0]      qx_reg, qx_next, qy_reg, qy_next;
    logic [12:0]      rx_reg, rx_next, ry_reg, ry_next;

    coord_t      x1s, y1s, x2s, y2s, x3s, y3s, dx, dy, wm, ew1, eh1;
    coord_t      xmin, xmax, ymin, ymax, lo_a, hi_a, lo_b, hi_b;
    logic [11:0] adx_c, ady_c;
    logic [12:0] two_steps;
    logic [13:0] rx_sum, ry_sum;
    logic        wr_issue;

    always_comb begin
        x1s  = coord_t'(cmd_reg.x1);
        y1s  = coord_t'(cmd_reg.y1);
        x2s  = coord_t'(cmd_reg.x2);
        y2s  = coord_t'(cmd_reg.y2);
        x3s  = coord_t'(cmd_reg.x3);
        y3s  = coord_t'(cmd_reg.y3);
        dx   = x2s - x1s;
        dy   = y2s - y1s;
        wm   = dx;
        adx_c = dx[CW-1] ? 12'(-dx) : 12'(dx);
        ady_c = dy[CW-1] ? 12'(-dy) : 12'(dy);
        xmin = (x1s < x2s) ? x1s : x2s;
        xmax = (x1s < x2s) ? x2s : x1s;
        ymin = (y1s < y2s) ? y1s : y2s;
        ymax = (y1s < y2s) ? y2s : y1s;
        ew1  = $signed({2'b00, eff_w}) - coord_t'(1);
        eh1  = $signed({2'b00, eff_h}) - coord_t'(1);
        two_steps = {steps_reg, 1'b0};
        rx_sum = {1'b0, rx_reg} + {1'b0, adx_reg, 1'b0};
        ry_sum = {1'b0, ry_reg} + {1'b0, ady_reg, 1'b0};
        // clipped loop bounds: fill uses the corners, copies the offsets
        if (cmd_reg.op == OP_FILL) begin
            lo_a = xmin[CW-1] ? coord_t'(0) : xmin;
            hi_a = (xmax > ew1) ? ew1 : xmax;
            lo_b = ymin[CW-1] ? coord_t'(0) : ymin;
            hi_b = (ymax > eh1) ? eh1 : ymax;
        end else begin
            lo_a = x3s[CW-1] ? -x3s : coord_t'(0);
            hi_a = ((ew1 - x3s) < wm) ? (ew1 - x3s) : wm;
            lo_b = y3s[CW-1] ? -y3s : coord_t'(0);
            hi_b = ((eh1 - y3s) < dy) ? (eh1 - y3s) : dy;
        end
    end

    // sequencer: next state, loop counters and the pixel request
    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        a_next     = a_reg;
        a_hi_next  = a_hi_reg;
        b_next     = b_reg;
        b_lo_next  = b_lo_reg;
        b_hi_next  = b_hi_reg;
        sub_next   = sub_reg;
        cnt_next   = cnt_reg;
        pix_next   = pix_reg;
        steps_next = steps_reg;
        adx_next   = adx_reg;
        ady_next   = ady_reg;
        qx_next    = qx_reg;
        qy_next    = qy_reg;
        rx_next    = rx_reg;
        ry_next    = ry_reg;
        req        = '0;
        req.data   = cmd_reg.color;
        wr_issue   = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    cmd_next   = cmd;
                    cnt_next   = '0;
                    pix_next   = '0;
                    state_next = S_SETUP;
                end
            end
            S_SETUP: begin
                case (cmd_reg.op)
                    OP_LINE: begin
                        a_next     = '0;
                        adx_next   = adx_c;
                        ady_next   = ady_c;
                        steps_next = (adx_c > ady_c) ? adx_c : ady_c;
                        qx_next    = '0;
                        qy_next    = '0;
                        rx_next    = {1'b0, ((adx_c > ady_c) ? adx_c : ady_c)};
                        ry_next    = {1'b0, ((adx_c > ady_c) ? adx_c : ady_c)};
                        state_next = S_LINE;
                    end
                    OP_OUTLINE: begin
                        a_next     = xmin;
                        a_hi_next  = xmax;
                        sub_next   = 1'b0;
                        state_next = S_OUT_H;
                    end
                    OP_READ: begin
                        state_next = S_READ_RD;
                    end
                    default: begin
                        a_next     = lo_a;
                        a_hi_next  = hi_a;
                        b_next     = lo_b;
                        b_lo_next  = lo_b;
                        b_hi_next  = hi_b;
                        if ((lo_a > hi_a) || (lo_b > hi_b)) begin
                            state_next = S_DONE;
                        end else if (cmd_reg.op == OP_FILL) begin
                            state_next = S_FILL;
                        end else begin
                            state_next = S_BLIT_RD;
                        end
                    end
                endcase
            end
            S_LINE: begin
                // point i: quotient of (2*i*|d| + steps) / (2*steps)
                req.wr   = 1'b1;
                req.x    = x1s + (dx[CW-1] ? -coord_t'(qx_reg) : coord_t'(qx_reg));
                req.y    = y1s + (dy[CW-1] ? -coord_t'(qy_reg) : coord_t'(qy_reg));
                wr_issue = 1'b1;
                if (a_reg == coord_t'(steps_reg)) begin
                    state_next = S_DONE;
                end else begin
                    a_next = a_reg + coord_t'(1);
                    if (rx_sum >= {1'b0, two_steps}) begin
                        rx_next = 13'(rx_sum - {1'b0, two_steps});
                        qx_next = qx_reg + 12'd1;
                    end else begin
                        rx_next = 13'(rx_sum);
                    end
                    if (ry_sum >= {1'b0, two_steps}) begin
                        ry_next = 13'(ry_sum - {1'b0, two_steps});
                        qy_next = qy_reg + 12'd1;
                    end else begin
                        ry_next = 13'(ry_sum);
                    end
                end
            end
            S_OUT_H: begin
                req.wr   = 1'b1;
                req.x    = a_reg;
                req.y    = sub_reg ? y2s : y1s;
                wr_issue = 1'b1;
                sub_next = !sub_reg;
                if (sub_reg) begin
                    if (a_reg == a_hi_reg) begin
                        a_next     = ymin;
                        a_hi_next  = ymax;
                        state_next = S_OUT_V;
                    end else begin
                        a_next = a_reg + coord_t'(1);
                    end
                end
            end
            S_OUT_V: begin
                req.wr   = 1'b1;
                req.x    = sub_reg ? x2s : x1s;
                req.y    = a_reg;
                wr_issue = 1'b1;
                sub_next = !sub_reg;
                if (sub_reg) begin
                    if (a_reg == a_hi_reg) begin
                        state_next = S_DONE;
                    end else begin
                        a_next = a_reg + coord_t'(1);
                    end
                end
            end
            S_FILL: begin
                req.wr   = 1'b1;
                req.x    = a_reg;
                req.y    = b_reg;
                wr_issue = 1'b1;
                if (b_reg == b_hi_reg) begin
                    b_next = b_lo_reg;
                    if (a_reg == a_hi_reg) begin
                        state_next = S_DONE;
                    end else begin
                        a_next = a_reg + coord_t'(1);
                    end
                end else begin
                    b_next = b_reg + coord_t'(1);
                end
            end
            S_BLIT_RD: begin
                req.rd = 1'b1;
                req.x  = (cmd_reg.op == OP_MIRROR_H) ? (x2s - a_reg) : (x1s + a_reg);
                req.y  = (cmd_reg.op == OP_MIRROR_V) ? (y2s - b_reg) : (y1s + b_reg);
                state_next = S_BLIT_WR;
            end
            S_BLIT_WR: begin
                req.wr   = 1'b1;
                req.x    = x3s + a_reg;
                req.y    = y3s + b_reg;
                req.data = (cmd_reg.op == OP_COPY_INV) ? (PMAX8 - rd_data) : rd_data;
                wr_issue = 1'b1;
                state_next = S_BLIT_RD;
                if (b_reg == b_hi_reg) begin
                    b_next = b_lo_reg;
                    if (a_reg == a_hi_reg) begin
                        state_next = S_DONE;
                    end else begin
                        a_next = a_reg + coord_t'(1);
                    end
                end else begin
                    b_next = b_reg + coord_t'(1);
                end
            end
            S_READ_RD: begin
                req.rd     = 1'b1;
                req.x      = x1s;
                req.y      = y1s;
                state_next = S_READ_WAIT;
            end
            S_READ_WAIT: begin
                pix_next   = rd_data;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (res_take) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // count writes that land inside the image
        if (wr_issue && hit && (cnt_reg != COUNT_MAX)) begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        a_reg     <= a_next;
        a_hi_reg  <= a_hi_next;
        b_reg     <= b_next;
        b_lo_reg  <= b_lo_next;
        b_hi_reg  <= b_hi_next;
        sub_reg   <= sub_next;
        cnt_reg   <= cnt_next;
        pix_reg   <= pix_next;
        steps_reg <= steps_next;
        adx_reg   <= adx_next;
        ady_reg   <= ady_next;
        qx_reg    <= qx_next;
        qy_reg    <= qy_next;
        rx_reg    <= rx_next;
        ry_reg    <= ry_next;
    end

    assign idle               = (state_reg == S_IDLE);
    assign done               = (state_reg == S_DONE);
    assign res.pixel_value    = pix_reg;
    assign res.pixels_written = cnt_reg;

endmodule

@@ hw/rtl/raster_draw_and_blit_engine.sv @@
`timescale 1ns / 1ps

// Grayscale drawing engine over an internal frame store of 8-bit pixels.
// Command words enter on the s_ channel (op on s_tuser, coordinates and
// color on s_tdata); each command gives exactly one result word on the m_
// channel: the pixel read (read command) and the count of pixels written.
// Image size is set through cfg_we/cfg_addr/cfg_wdata while idle.
// The frame store sees at most one access per cycle; empty fills or
// copies go straight to the result.
// After reset the frame store is cleared one pixel per cycle, all
// MAX_WIDTH*MAX_HEIGHT pixels (65536 by default); s_tready stays low then.
// One command is worked on at a time. A finished result sits in the output
// register; the next command is taken meanwhile, but its result waits
// until the receiver takes the pending word, so m_tready low stalls only
// the engine's final step.

module raster_draw_and_blit_engine
    import rdbe_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int PIXEL_MAX  = 255
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // x1, y1, x2, y2, x3, y3, color
    input  logic [2:0]  s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // pixel_value, pixels_written
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [8:0]  cfg_wdata
);

    logic [8:0]       width_reg, height_reg;
    logic [DIM_W-1:0] eff_w, eff_h;
    cmd_t             cmd;
    px_req_t          req;
    res_t             res, out_reg, out_next;
    logic             out_valid_reg, out_valid_next;
    logic             hit, clr_busy, seq_idle, seq_done, res_take;
    logic [7:0]       rd_data;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
        end else if (cfg_we) begin
            if (cfg_addr == REG_WIDTH) begin
                width_reg <= cfg_wdata;
            end
            if (cfg_addr == REG_HEIGHT) begin
                height_reg <= cfg_wdata;
            end
        end
    end

    // size in use: zero acts as one, clamp to the store size
    always_comb begin
        if (width_reg == 9'd0) begin
            eff_w = DIM_W'(1);
        end else if ({3'b000, width_reg} > DIM_W'(MAX_WIDTH)) begin
            eff_w = DIM_W'(MAX_WIDTH);
        end else begin
            eff_w = {3'b000, width_reg};
        end
        if (height_reg == 9'd0) begin
            eff_h = DIM_W'(1);
        end else if ({3'b000, height_reg} > DIM_W'(MAX_HEIGHT)) begin
            eff_h = DIM_W'(MAX_HEIGHT);
        end else begin
            eff_h = {3'b000, height_reg};
        end
    end

    // command word unpack
    always_comb begin
        cmd.op    = op_t'(s_tuser);
        cmd.x1    = s_tdata[11:0];
        cmd.y1    = s_tdata[23:12];
        cmd.x2    = s_tdata[35:24];
        cmd.y2    = s_tdata[47:36];
        cmd.x3    = s_tdata[59:48];
        cmd.y3    = s_tdata[71:60];
        cmd.color = s_tdata[79:72];
    end

    assign s_tready = seq_idle && !clr_busy;

    rdbe_seq #(
        .PIXEL_MAX (PIXEL_MAX)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_tvalid && s_tready),
        .cmd      (cmd),
        .eff_w    (eff_w),
        .eff_h    (eff_h),
        .idle     (seq_idle),
        .done     (seq_done),
        .res_take (res_take),
        .res      (res),
        .req      (req),
        .hit      (hit),
        .rd_data  (rd_data)
    );

    rdbe_fb #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_fb (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .eff_w    (eff_w),
        .eff_h    (eff_h),
        .req      (req),
        .hit      (hit),
        .rd_data  (rd_data),
        .clr_busy (clr_busy)
    );

    // output register
    assign res_take = seq_done && (!out_valid_reg || m_tready);

    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (res_take) begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.pixels_written, out_reg.pixel_value};

    // no command is taken during the clearing pass
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy |-> !s_tready)
        else $error("command accepted during frame store clear");

    // one command at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second command accepted while busy");

    // a new result word only comes from a finished command
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(seq_done))
        else $error("result word without finished command");

    // the store is never written while a result is handed over
    a_no_write_when_done: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_done |-> !req.wr && !req.rd)
        else $error("frame store access in done state");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import rdbe_pkg::*;

    localparam int FB_W = 256;
    localparam int FB_H = 256;
    localparam int SAT = 131071;
    localparam int PIXEL_MAX_TB = 255;

    typedef struct {
        op_t               op;
        logic signed [11:0] x1, y1, x2, y2, x3, y3;
        logic [7:0]         color;
    } draw_cmd_t;

    typedef struct {
        logic [7:0]  pix;
        logic [16:0] cnt;
    } draw_res_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [31:0] m_tdata;
    logic        cfg_we = 0;
    logic        cfg_addr = REG_WIDTH;
    logic [8:0]  cfg_wdata = '0;

    raster_draw_and_blit_engine uut (.*);

    // shadow frame store and size registers
    logic [7:0] frame_px [0:FB_W*FB_H-1];
    int         img_w_reg, img_h_reg;

    draw_cmd_t  pending_cmds[$];
    draw_res_t  awaited_results[$];
    draw_cmd_t  in_flight;
    int         mismatches = 0;
    int         send_idle_pct = 0, recv_stall_pct = 0;
    int         hold_req = 0, hold_seen = 0, hold_left = 0;

    initial forever #2 aclk = ~aclk;

    initial begin
        #200_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int eff_w();
        return img_w_reg == 0 ? 1 : (img_w_reg > FB_W ? FB_W : img_w_reg);
    endfunction

    function automatic int eff_h();
        return img_h_reg == 0 ? 1 : (img_h_reg > FB_H ? FB_H : img_h_reg);
    endfunction

    function automatic void plot(int x, int y, logic [7:0] c, ref int cnt);
        if (x < 0 || y < 0 || x >= eff_w() || y >= eff_h()) return;
        frame_px[y*FB_W + x] = c;
        if (cnt < SAT) cnt++;
    endfunction

    function automatic logic [7:0] sample(int x, int y);
        if (x < 0 || y < 0 || x >= eff_w() || y >= eff_h()) return 8'd0;
        return frame_px[y*FB_W + x];
    endfunction

    // round half away from zero, d > 0
    function automatic int round_div(longint n, longint d);
        longint m, q;
        m = n < 0 ? -n : n;
        q = (2*m + d) / (2*d);
        return int'(n < 0 ? -q : q);
    endfunction

    // applies one command to the shadow frame store, returns its result word
    function automatic draw_res_t predict_result(draw_cmd_t c);
        draw_res_t r;
        int x1, y1, x2, y2, x3, y3, dx, dy, steps, lo, hi, a, b, w, h, cnt;
        int alo, ahi, blo, bhi;
        logic [7:0] v;
        x1 = c.x1; y1 = c.y1; x2 = c.x2; y2 = c.y2; x3 = c.x3; y3 = c.y3;
        cnt = 0;
        r.pix = 8'd0;
        case (c.op)
            OP_LINE: begin
                dx = x2 - x1; dy = y2 - y1;
                steps = (dx < 0 ? -dx : dx);
                if ((dy < 0 ? -dy : dy) > steps) steps = dy < 0 ? -dy : dy;
                if (steps == 0) plot(x1, y1, c.color, cnt);
                else for (int i = 0; i <= steps; i++)
                    plot(x1 + round_div(longint'(i)*dx, steps),
                         y1 + round_div(longint'(i)*dy, steps), c.color, cnt);
            end
            OP_OUTLINE: begin
                lo = x1 < x2 ? x1 : x2; hi = x1 < x2 ? x2 : x1;
                for (a = lo; a <= hi; a++) begin
                    plot(a, y1, c.color, cnt);
                    plot(a, y2, c.color, cnt);
                end
                lo = y1 < y2 ? y1 : y2; hi = y1 < y2 ? y2 : y1;
                for (a = lo; a <= hi; a++) begin
                    plot(x1, a, c.color, cnt);
                    plot(x2, a, c.color, cnt);
                end
            end
            OP_FILL: begin
                alo = x1 < x2 ? x1 : x2; ahi = x1 < x2 ? x2 : x1;
                blo = y1 < y2 ? y1 : y2; bhi = y1 < y2 ? y2 : y1;
                if (alo < 0) alo = 0;
                if (blo < 0) blo = 0;
                if (ahi > eff_w() - 1) ahi = eff_w() - 1;
                if (bhi > eff_h() - 1) bhi = eff_h() - 1;
                for (a = alo; a <= ahi; a++)
                    for (b = blo; b <= bhi; b++) plot(a, b, c.color, cnt);
            end
            OP_READ: r.pix = sample(x1, y1);
            default: begin
                w = x2 - x1 + 1; h = y2 - y1 + 1;
                alo = -x3 > 0 ? -x3 : 0;
                ahi = (eff_w() - 1 - x3) < w - 1 ? eff_w() - 1 - x3 : w - 1;
                blo = -y3 > 0 ? -y3 : 0;
                bhi = (eff_h() - 1 - y3) < h - 1 ? eff_h() - 1 - y3 : h - 1;
                if (w >= 1 && h >= 1) begin
                    for (a = alo; a <= ahi; a++)
                        for (b = blo; b <= bhi; b++) begin
                            if (c.op == OP_MIRROR_H) v = sample(x2 - a, y1 + b);
                            else if (c.op == OP_MIRROR_V) v = sample(x1 + a, y2 - b);
                            else v = sample(x1 + a, y1 + b);
                            if (c.op == OP_COPY_INV) v = 8'(PIXEL_MAX_TB - v);
                            plot(x3 + a, y3 + b, v, cnt);
                        end
                end
            end
        endcase
        r.cnt = 17'(cnt);
        return r;
    endfunction

    // word source: one command held on s_ until taken
    always @(posedge aclk) begin
        if (s_tvalid && s_tready) awaited_results.push_back(predict_result(in_flight));
        if (!s_tvalid || s_tready) begin
            if (aresetn && pending_cmds.size() > 0 &&
                $urandom_range(0, 99) >= send_idle_pct) begin
                in_flight = pending_cmds.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= in_flight.op;
                s_tdata  <= {in_flight.color, in_flight.y3, in_flight.x3,
                             in_flight.y2, in_flight.x2, in_flight.y1, in_flight.x1};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold, counted in cycles
    always @(posedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= 600;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result sink and checker
    always @(posedge aclk) begin
        draw_res_t e;
        if (m_tvalid && m_tready) begin
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", m_tdata);
            end else begin
                e = awaited_results.pop_front();
                if (m_tdata[7:0] !== e.pix || m_tdata[24:8] !== e.cnt) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: pixel exp %0d got %0d, written exp %0d got %0d",
                                 e.pix, m_tdata[7:0], e.cnt, m_tdata[24:8]);
                end
            end
        end
        if (hold_req != hold_seen || hold_left > 0) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= $urandom_range(0, 99) >= recv_stall_pct;
        end
    end

    function automatic logic signed [11:0] pick(int n);
        int r;
        r = $urandom_range(0, 99);
        if (r < 2) return 12'($urandom);
        if (r < 10) case ($urandom_range(0, 3))
            0: return -12'sd1;
            1: return 12'sd0;
            2: return 12'(n - 1);
            default: return 12'(n);
        endcase
        return 12'(int'($urandom_range(0, n + 7)) - 4);
    endfunction

    function automatic draw_cmd_t random_cmd();
        draw_cmd_t c;
        int w, h;
        w = eff_w(); h = eff_h();
        c.op = op_t'($urandom_range(0, 7));
        c.x1 = pick(w); c.y1 = pick(h);
        c.color = 8'($urandom);
        // large areas only where the image is small
        if (c.op inside {OP_LINE, OP_OUTLINE, OP_READ} || w*h <= 4096) begin
            c.x2 = pick(w); c.y2 = pick(h);
        end else begin
            c.x2 = c.x1 + 12'(int'($urandom_range(0, 18)) - 3);
            c.y2 = c.y1 + 12'(int'($urandom_range(0, 18)) - 3);
        end
        if ($urandom_range(0, 3) == 0) begin
            c.x3 = 12'($urandom); c.y3 = 12'($urandom);
        end else begin
            c.x3 = pick(w); c.y3 = pick(h);
        end
        return c;
    endfunction

    function automatic draw_cmd_t mk(op_t op, int x1, int y1, int x2, int y2,
                                     int x3, int y3, int color);
        draw_cmd_t c;
        c.op = op; c.x1 = 12'(x1); c.y1 = 12'(y1); c.x2 = 12'(x2); c.y2 = 12'(y2);
        c.x3 = 12'(x3); c.y3 = 12'(y3); c.color = 8'(color);
        return c;
    endfunction

    task automatic drain();
        while (pending_cmds.size() > 0 || s_tvalid || awaited_results.size() > 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic set_size(int w, int h);
        @(posedge aclk);
        cfg_we <= 1'b1; cfg_addr <= REG_WIDTH; cfg_wdata <= 9'(w);
        @(posedge aclk);
        cfg_addr <= REG_HEIGHT; cfg_wdata <= 9'(h);
        @(posedge aclk);
        cfg_we <= 1'b0;
        img_w_reg = w; img_h_reg = h;
    endtask

    task automatic run_phase(int w, int h, int idle, int stall, int n, bit hold);
        set_size(w, h);
        send_idle_pct = idle; recv_stall_pct = stall;
        for (int i = 0; i < n; i++) pending_cmds.push_back(random_cmd());
        if (hold) hold_req++;
        drain();
    endtask

    initial begin
        for (int i = 0; i < FB_W*FB_H; i++) frame_px[i] = 8'd0;
        img_w_reg = 256; img_h_reg = 256;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, every op, clipping and degenerate shapes
        set_size(256, 256);
        pending_cmds.push_back(mk(OP_READ, 0, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk(OP_FILL, -2048, -2048, 2047, 2047, 0, 0, 255));
        pending_cmds.push_back(mk(OP_FILL, 10, 20, 3, 5, 0, 0, 17));
        pending_cmds.push_back(mk(OP_LINE, 5, 5, 5, 5, 0, 0, 200));
        pending_cmds.push_back(mk(OP_LINE, -2048, -100, 2047, 300, 0, 0, 90));
        pending_cmds.push_back(mk(OP_LINE, 0, 0, 7, 3, 0, 0, 33));
        pending_cmds.push_back(mk(OP_LINE, 20, 0, 13, -5, 0, 0, 44));
        pending_cmds.push_back(mk(OP_OUTLINE, 30, 40, 20, 30, 0, 0, 128));
        pending_cmds.push_back(mk(OP_OUTLINE, 50, 50, 50, 50, 0, 0, 1));
        pending_cmds.push_back(mk(OP_OUTLINE, -5, 250, 260, 255, 0, 0, 77));
        pending_cmds.push_back(mk(OP_COPY, 0, 0, 63, 63, 100, 100, 0));
        pending_cmds.push_back(mk(OP_COPY_INV, 2, 2, 20, 9, 30, 60, 0));
        pending_cmds.push_back(mk(OP_COPY_INV, -4, -4, 5, 5, 250, 250, 0));
        pending_cmds.push_back(mk(OP_MIRROR_H, 0, 0, 15, 7, 5, 3, 0));
        pending_cmds.push_back(mk(OP_MIRROR_V, 0, 0, 9, 15, 3, 5, 0));
        pending_cmds.push_back(mk(OP_COPY, 10, 10, 9, 20, 0, 0, 0));
        pending_cmds.push_back(mk(OP_COPY, 0, 0, 3, 3, -2048, 2047, 0));
        pending_cmds.push_back(mk(OP_READ, 255, 255, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk(OP_READ, 256, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk(OP_READ, -1, 3, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk(OP_READ, 101, 102, 0, 0, 0, 0, 0));
        drain();

        // random phases over several image sizes and flow patterns
        run_phase(256, 256, 0, 0, 250, 1'b0);
        run_phase(40, 30, 48, 0, 250, 1'b1);
        run_phase(1, 1, 0, 48, 150, 1'b0);
        run_phase(0, 511, 20, 20, 150, 1'b0);
        run_phase(511, 0, 48, 48, 150, 1'b0);
        run_phase(17, 200, 0, 0, 200, 1'b1);
        run_phase(256, 256, 20, 20, 200, 1'b0);
        run_phase(64, 64, 48, 0, 200, 1'b0);

        repeat (100) @(posedge aclk);
        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
